@@ src/fp8bsd_pkg.sv @@
// Shared constants, types and weight decoding for the FP8 block-scaled dot product.
`timescale 1ns / 1ps

package fp8bsd_pkg;

  localparam int BLOCK_SIZE_DEF  = 128;
  localparam int MAX_COLUMNS_DEF = 8192;

  localparam int CODE_W     = 8;
  localparam int DATA_W     = 32;
  localparam int RESULT_W   = 64;
  localparam int WMAG_W     = 18;
  localparam int PROD_W     = 50;
  localparam int ROW_LEN_W  = 14;
  localparam int ROW_CNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int ROUND_SHIFT = 25;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 14'd128;
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST  = 16'd1;

  localparam logic signed [RESULT_W-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [RESULT_W-1:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_ROW_COUNT  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W-1:0] scale;
    logic                     nan;
    logic                     close;
    logic                     row_end;
    logic                     final_row;
  } q_entry_t;

  // Magnitude of an E4M3 weight in units of 2^-9.
  function automatic logic [WMAG_W-1:0] weight_mag(input logic [CODE_W-1:0] code);
    logic [3:0]        e;
    logic [2:0]        m;
    logic [WMAG_W-1:0] base;
    e    = code[6:3];
    m    = code[2:0];
    base = WMAG_W'({1'b1, m});
    if (e == 4'd0) begin
      return WMAG_W'(m);
    end
    return base << (e - 4'd1);
  endfunction

  function automatic logic weight_is_nan(input logic [CODE_W-1:0] code);
    return code[6:0] == 7'h7F;
  endfunction

endpackage

@@ src/fp8bsd_if.sv @@
// Channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps

interface fp8bsd_data_if;
  import fp8bsd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CODE_W-1:0]        weight_code;
  logic signed [DATA_W-1:0] activation;
  logic signed [DATA_W-1:0] block_scale;
  modport source (output valid, weight_code, activation, block_scale, input ready);
  modport sink (input valid, weight_code, activation, block_scale, output ready);
endinterface

interface fp8bsd_result_if;
  import fp8bsd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] dot_result;
  logic                       final_row;
  logic                       nan_seen;
  logic                       saturated;
  modport source (output valid, dot_result, final_row, nan_seen, saturated, input ready);
  modport sink (input valid, dot_result, final_row, nan_seen, saturated, output ready);
endinterface

interface fp8bsd_cfg_if;
  import fp8bsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/fp8bsd_front.sv @@
// Front end: configuration registers, column and row tracking, weight decode and product.
`timescale 1ns / 1ps

module fp8bsd_front #(
  parameter int BLOCK_SIZE  = fp8bsd_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_COLUMNS = fp8bsd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  fp8bsd_data_if.sink          data,
  fp8bsd_cfg_if.sink           cfg,
  output logic                 push_valid,
  input  logic                 push_ready,
  output fp8bsd_pkg::q_entry_t push_data
);
  import fp8bsd_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int BLK_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  logic [ROW_LEN_W-1:0] row_length;
  logic [ROW_CNT_W-1:0] row_count;
  logic [COL_W-1:0]     column_index;
  logic [BLK_W-1:0]     block_index;
  logic [ROW_CNT_W-1:0] row_index;

  logic [COL_W-1:0]            len;
  logic [COL_W-1:0]            taken;
  logic [ROW_CNT_W-1:0]        row_index_inc;
  logic                        row_end;
  logic                        block_end;
  logic                        final_row;
  logic                        nan;
  logic [WMAG_W-1:0]           mag;
  logic signed [WMAG_W:0]      weight_val;
  logic signed [WMAG_W+DATA_W:0] prod_full;
  logic                        accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RST;
      row_count  <= ROW_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ROW_LENGTH: row_length <= cfg.data[ROW_LEN_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg.data[ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length == '0) begin
      len = COL_W'(1);
    end else if (32'(row_length) > MAX_COLUMNS) begin
      len = COL_W'(MAX_COLUMNS);
    end else begin
      len = COL_W'(row_length);
    end
  end

  assign taken         = column_index + COL_W'(1);
  assign row_end       = taken >= len;
  assign block_end     = block_index == BLK_W'(BLOCK_SIZE - 1);
  assign row_index_inc = row_index + ROW_CNT_W'(1);
  assign final_row     = row_index_inc == row_count;

  assign nan        = weight_is_nan(data.weight_code);
  assign mag        = weight_mag(data.weight_code);
  assign weight_val = data.weight_code[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign prod_full  = weight_val * data.activation;

  assign push_valid           = data.valid;
  assign data.ready           = push_ready;
  assign accept               = data.valid && push_ready;
  assign push_data.prod       = nan ? '0 : prod_full[PROD_W-1:0];
  assign push_data.scale      = data.block_scale;
  assign push_data.nan        = nan;
  assign push_data.close      = row_end || block_end;
  assign push_data.row_end    = row_end;
  assign push_data.final_row  = row_end && final_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      block_index  <= '0;
      row_index    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_index <= '0;
        block_index  <= '0;
        row_index    <= final_row ? '0 : row_index_inc;
      end else begin
        column_index <= taken;
        block_index  <= block_end ? '0 : block_index + BLK_W'(1);
      end
    end
  end

endmodule

@@ src/fp8bsd_queue.sv @@
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps

module fp8bsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  fp8bsd_pkg::q_entry_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output fp8bsd_pkg::q_entry_t pop_data
);
  import fp8bsd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/fp8bsd_back.sv @@
// Back end: block accumulation, scaling with rounding, saturating row total and result register.
`timescale 1ns / 1ps

module fp8bsd_back #(
  parameter int BLOCK_SIZE = fp8bsd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  fp8bsd_pkg::q_entry_t pop_data,
  fp8bsd_result_if.source      result
);
  import fp8bsd_pkg::*;

  localparam int PART_W  = PROD_W + $clog2(BLOCK_SIZE) + 1;
  localparam int FULL_W  = PART_W + DATA_W + 1;
  localparam int R_W     = (FULL_W - ROUND_SHIFT > 65) ? FULL_W - ROUND_SHIFT : 65;
  localparam logic [2*DATA_W-1:0] ROUND_HALF = (2*DATA_W)'(1) << (ROUND_SHIFT - 1);
  localparam logic [R_W-1:0] R_POS_MAX = R_W'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [R_W-1:0] R_NEG_MAX = R_W'(64'h8000_0000_0000_0000);

  typedef enum logic [5:0] {
    S_ACC = 6'b000001,
    S_MAG = 6'b000010,
    S_MLO = 6'b000100,
    S_MHI = 6'b001000,
    S_RND = 6'b010000,
    S_ADD = 6'b100000
  } state_t;

  state_t                     state;
  logic signed [PART_W-1:0]   partial;
  logic signed [RESULT_W-1:0] row_total;
  logic                       nan_flag;
  logic                       sat_flag;
  logic                       out_valid;

  logic signed [DATA_W-1:0]   scale_r;
  logic                       row_end_r;
  logic                       final_r;
  logic [PART_W-1:0]          pm;
  logic [DATA_W-1:0]          sm;
  logic                       neg;
  logic [2*DATA_W-1:0]        plo;
  logic [PART_W-1:0]          phi;
  logic signed [RESULT_W-1:0] term;
  logic                       term_sat;
  logic signed [RESULT_W-1:0] dot_result;
  logic                       final_row;
  logic                       nan_seen;
  logic                       saturated;

  logic signed [PART_W-1:0]   acc_sum;
  logic [FULL_W-1:0]          full;
  logic [R_W-1:0]             rounded;
  logic signed [RESULT_W-1:0] total_sum;
  logic                       total_ovf;
  logic signed [RESULT_W-1:0] new_total;
  logic                       new_sat;
  logic                       advance;
  logic                       pop_fire;

  assign pop_ready = state == S_ACC;
  assign pop_fire  = pop_valid && pop_ready;
  assign acc_sum   = partial + PART_W'(pop_data.prod);

  assign full    = (FULL_W'(phi) << DATA_W) + FULL_W'(plo);
  assign rounded = R_W'(full >> ROUND_SHIFT);

  assign total_sum = row_total + term;
  assign total_ovf = (row_total[RESULT_W-1] == term[RESULT_W-1])
                     && (total_sum[RESULT_W-1] != row_total[RESULT_W-1]);
  assign new_total = total_ovf ? (row_total[RESULT_W-1] ? S64_MIN : S64_MAX) : total_sum;
  assign new_sat   = sat_flag || term_sat || total_ovf;
  assign advance   = !row_end_r || !out_valid || result.ready;

  assign result.valid      = out_valid;
  assign result.dot_result = dot_result;
  assign result.final_row  = final_row;
  assign result.nan_seen   = nan_seen;
  assign result.saturated  = saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      partial   <= '0;
      row_total <= '0;
      nan_flag  <= 1'b0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_ADD && advance && row_end_r) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_ACC: begin
          if (pop_fire) begin
            partial <= acc_sum;
            if (pop_data.nan) begin
              nan_flag <= 1'b1;
            end
            if (pop_data.close) begin
              state <= S_MAG;
            end
          end
        end
        S_MAG: begin
          partial <= '0;
          state   <= S_MLO;
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_RND;
        S_RND: state <= S_ADD;
        S_ADD: begin
          if (advance) begin
            state <= S_ACC;
            if (row_end_r) begin
              row_total <= '0;
              nan_flag  <= 1'b0;
              sat_flag  <= 1'b0;
            end else begin
              row_total <= new_total;
              sat_flag  <= new_sat;
            end
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire && pop_data.close) begin
      scale_r   <= pop_data.scale;
      row_end_r <= pop_data.row_end;
      final_r   <= pop_data.final_row;
    end
    if (state == S_MAG) begin
      pm  <= partial[PART_W-1] ? PART_W'(-partial) : PART_W'(partial);
      sm  <= scale_r[DATA_W-1] ? (~scale_r + DATA_W'(1)) : scale_r;
      neg <= partial[PART_W-1] ^ scale_r[DATA_W-1];
    end
    if (state == S_MLO) begin
      plo <= (2*DATA_W)'(pm[DATA_W-1:0]) * (2*DATA_W)'(sm);
    end
    if (state == S_MHI) begin
      phi <= PART_W'(pm[PART_W-1:DATA_W]) * PART_W'(sm);
      plo <= plo + ROUND_HALF;
    end
    if (state == S_RND) begin
      if (!neg) begin
        term_sat <= rounded > R_POS_MAX;
        term     <= (rounded > R_POS_MAX) ? S64_MAX : RESULT_W'(rounded);
      end else begin
        term_sat <= rounded > R_NEG_MAX;
        term     <= (rounded > R_NEG_MAX) ? S64_MIN : -RESULT_W'(rounded);
      end
    end
    if (state == S_ADD && advance && row_end_r) begin
      dot_result <= new_total;
      final_row  <= final_r;
      nan_seen   <= nan_flag;
      saturated  <= new_sat;
    end
  end

endmodule

@@ src/fp8_block_scaled_dot_product.sv @@
// Top level of the FP8 E4M3 block-scaled dot product engine.
//
// Items arrive on the data channel, one weight byte, one Q16.16 activation and the
// Q16.16 block scale per item; an item is taken when valid and ready are both high.
// At the last column of each row one result item leaves on the result channel with
// the saturated Q47.16 row total and its final-row, NaN and saturation flags.
// Row length and row count are written through the cfg channel, which is always ready.
// The front end classifies each item and forms its weight product in the cycle it is
// accepted; a four-entry queue feeds the back end. The back end adds one item per cycle
// into the block sum while it is accumulating; an item that closes a block holds it
// in the magnitude, low product, high product, rounding and add states while the
// sum is scaled by two partial products, rounded and added to the row total.
// The result register is loaded in the add state of the block that ends the row.
// While the receiver stalls the result register holds its item; the back end then waits
// at the next row end and the queue fills until the data channel drops ready.
// Synchronous reset restores row length 128 and row count 1 and clears all sums,
// flags, counters, the queue and the valid flag of the result register.
`timescale 1ns / 1ps

module fp8_block_scaled_dot_product #(
  parameter int BLOCK_SIZE  = fp8bsd_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_COLUMNS = fp8bsd_pkg::MAX_COLUMNS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  fp8bsd_data_if.sink     data,
  fp8bsd_result_if.source result,
  fp8bsd_cfg_if.sink      cfg
);
  import fp8bsd_pkg::*;

  logic     q_push_valid;
  logic     q_push_ready;
  q_entry_t q_push_data;
  logic     q_pop_valid;
  logic     q_pop_ready;
  q_entry_t q_pop_data;

  fp8bsd_front #(
    .BLOCK_SIZE  (BLOCK_SIZE),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .data       (data),
    .cfg        (cfg),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  fp8bsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  fp8bsd_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .result    (result)
  );

`ifndef ASSERT_OFF
  a_row_end_closes_block: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && q_push_data.row_end |-> q_push_data.close)
    else $error("A row end item does not close its block.");

  a_final_only_at_row_end: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && q_push_data.final_row |-> q_push_data.row_end)
    else $error("An item marked as final row is not a row end.");

  a_nan_adds_nothing: assert property (@(posedge clk) disable iff (rst)
    q_pop_valid && q_pop_data.nan |-> q_pop_data.prod == '0)
    else $error("A NaN weight item carries a nonzero product.");
`endif

endmodule
